// ----- rtl/core/dlts_pkg.sv -----
`default_nettype none

package dlts_pkg;

    localparam int TASK_COUNT   = 26;
    localparam int WORKER_COUNT = 5;

    localparam int TASK_W   = 5;
    localparam int WORKER_W = 3;
    localparam int FIN_W    = $clog2(TASK_COUNT + 1);
    localparam int REM_W    = 9;
    localparam int TICK_W   = 16;
    localparam int BASE_W   = 8;
    localparam int ACT_W    = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [BASE_W-1:0] DURATION_BASE_RESET  = 8'd61;
    localparam logic [ACT_W-1:0]  ACTIVE_WORKERS_RESET = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_DURATION_BASE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WORKERS = 4'd1;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [TASK_W-1:0] before_task;
        logic [TASK_W-1:0] after_task;
    } in_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_res;
        logic [TICK_W-1:0] finish_tick;
        logic              deadlock;
        logic              last;
    } out_t;

    typedef struct packed {
        logic                load_edge;
        logic                start_run;
        logic                tick;
        logic                assign_w;
        logic                retire_w;
        logic                emit_deadlock;
        logic [WORKER_W-1:0] worker;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic finishing;
        logic out_free;
        logic all_done;
        logic last_worker;
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_ASSIGN,
        ST_CHECK,
        ST_DEAD,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/dlts_ctrl.sv -----
`default_nettype none

module dlts_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_kind,
    output logic                     in_ready,
    input  wire dlts_pkg::status_t   status,
    output dlts_pkg::cmd_t           cmd
);

    dlts_pkg::state_t                  state_reg, state_next;
    logic [dlts_pkg::WORKER_W-1:0]     w_reg, w_next;
    logic                              stall;

    assign stall = status.finishing && !status.out_free;

    always_comb
    begin
        state_next = state_reg;
        w_next     = w_reg;
        unique case (state_reg)
            dlts_pkg::ST_IDLE:
            begin
                if (in_valid && in_kind == dlts_pkg::KIND_RUN)
                    state_next = dlts_pkg::ST_TICK;
            end
            dlts_pkg::ST_TICK:
            begin
                w_next = '0;
                if (status.all_done)
                    state_next = dlts_pkg::ST_IDLE;
                else
                    state_next = dlts_pkg::ST_ASSIGN;
            end
            dlts_pkg::ST_ASSIGN:
            begin
                if (status.last_worker)
                begin
                    w_next     = '0;
                    state_next = dlts_pkg::ST_CHECK;
                end
                else
                    w_next = w_reg + 1'b1;
            end
            dlts_pkg::ST_CHECK:
            begin
                w_next = '0;
                if (status.busy)
                    state_next = dlts_pkg::ST_FINISH;
                else
                    state_next = dlts_pkg::ST_DEAD;
            end
            dlts_pkg::ST_DEAD:
            begin
                if (status.out_free)
                    state_next = dlts_pkg::ST_IDLE;
            end
            dlts_pkg::ST_FINISH:
            begin
                if (!stall)
                begin
                    if (status.last_worker)
                        state_next = dlts_pkg::ST_TICK;
                    else
                        w_next = w_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = dlts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready          = (state_reg == dlts_pkg::ST_IDLE);
        cmd.load_edge     = in_ready && in_valid && (in_kind == dlts_pkg::KIND_EDGE);
        cmd.start_run     = in_ready && in_valid && (in_kind == dlts_pkg::KIND_RUN);
        cmd.tick          = (state_reg == dlts_pkg::ST_TICK) && !status.all_done;
        cmd.assign_w      = (state_reg == dlts_pkg::ST_ASSIGN);
        cmd.retire_w      = (state_reg == dlts_pkg::ST_FINISH) && !stall;
        cmd.emit_deadlock = (state_reg == dlts_pkg::ST_DEAD) && status.out_free;
        cmd.worker        = w_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlts_pkg::ST_IDLE;
            w_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            w_reg     <= w_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dlts_datapath.sv -----
`default_nettype none

module dlts_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dlts_pkg::cmd_t                    cmd,
    input  wire dlts_pkg::in_t                     in_data,
    input  wire logic                              cfg_valid,
    input  wire logic [dlts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dlts_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dlts_pkg::status_t                      status,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output dlts_pkg::out_t                         out_data
);

    localparam int TC = dlts_pkg::TASK_COUNT;
    localparam int WC = dlts_pkg::WORKER_COUNT;

    logic [TC-1:0]                 masks_reg [TC];
    logic [TC-1:0]                 masks_next [TC];
    logic [TC-1:0]                 begun_reg, begun_next;
    logic [TC-1:0]                 done_reg, done_next;
    logic [dlts_pkg::REM_W-1:0]    rem_reg [WC];
    logic [dlts_pkg::REM_W-1:0]    rem_next [WC];
    logic [dlts_pkg::TASK_W-1:0]   cur_reg [WC];
    logic [dlts_pkg::TASK_W-1:0]   cur_next [WC];
    logic [dlts_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [dlts_pkg::FIN_W-1:0]    fin_reg, fin_next;
    logic [dlts_pkg::BASE_W-1:0]   base_reg, base_next;
    logic [dlts_pkg::ACT_W-1:0]    act_reg, act_next;
    logic                          out_valid_reg, out_valid_next;
    dlts_pkg::out_t                out_reg, out_next;

    logic [TC-1:0]                 ready_vec;
    logic                          any_ready;
    logic [dlts_pkg::TASK_W-1:0]   pick;
    logic [dlts_pkg::REM_W-1:0]    dur;
    logic [dlts_pkg::ACT_W-1:0]    nw;
    logic                          edge_ok;
    logic [dlts_pkg::REM_W-1:0]    rem_sel;

    // ready: not begun, every prerequisite done
    always_comb
    begin
        for (int t = 0; t < TC; t++)
            ready_vec[t] = !begun_reg[t] && ((masks_reg[t] & ~done_reg) == '0);
        any_ready = |ready_vec;
        pick = '0;
        for (int t = TC - 1; t >= 0; t--)
            if (ready_vec[t])
                pick = dlts_pkg::TASK_W'(t);
        dur = dlts_pkg::REM_W'(base_reg) + dlts_pkg::REM_W'(pick);
        if (dur == '0)
            dur = dlts_pkg::REM_W'(1);
    end

    always_comb
    begin
        if (act_reg == '0)
            nw = dlts_pkg::ACT_W'(1);
        else if (act_reg > dlts_pkg::ACT_W'(WC))
            nw = dlts_pkg::ACT_W'(WC);
        else
            nw = act_reg;
        rem_sel = rem_reg[cmd.worker];
        status.busy = 1'b0;
        for (int w = 0; w < WC; w++)
            if ((dlts_pkg::ACT_W'(w) < nw) && (rem_reg[w] != '0))
                status.busy = 1'b1;
        status.finishing   = (rem_sel == dlts_pkg::REM_W'(1));
        status.out_free    = !out_valid_reg || out_ready;
        status.all_done    = (fin_reg == dlts_pkg::FIN_W'(TC));
        status.last_worker = (dlts_pkg::ACT_W'(cmd.worker) == nw - 1'b1);
        edge_ok = ({1'b0, in_data.before_task} < (dlts_pkg::TASK_W + 1)'(TC))
               && ({1'b0, in_data.after_task} < (dlts_pkg::TASK_W + 1)'(TC));
    end

    always_comb
    begin
        masks_next     = masks_reg;
        begun_next     = begun_reg;
        done_next      = done_reg;
        rem_next       = rem_reg;
        cur_next       = cur_reg;
        tick_next      = tick_reg;
        fin_next       = fin_reg;
        base_next      = base_reg;
        act_next       = act_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_valid)
        begin
            if (cfg_index == dlts_pkg::REG_DURATION_BASE)
                base_next = cfg_data;
            else if (cfg_index == dlts_pkg::REG_ACTIVE_WORKERS)
                act_next = cfg_data[dlts_pkg::ACT_W-1:0];
        end

        if (cmd.load_edge && edge_ok)
            masks_next[in_data.after_task][in_data.before_task] = 1'b1;

        if (cmd.start_run)
        begin
            begun_next = '0;
            done_next  = '0;
            tick_next  = '0;
            fin_next   = '0;
            for (int w = 0; w < WC; w++)
            begin
                rem_next[w] = '0;
                cur_next[w] = '0;
            end
        end

        if (cmd.tick && tick_reg != '1)
            tick_next = tick_reg + 1'b1;

        if (cmd.assign_w && rem_sel == '0 && any_ready)
        begin
            rem_next[cmd.worker] = dur;
            cur_next[cmd.worker] = pick;
            begun_next[pick]     = 1'b1;
        end

        if (cmd.retire_w)
        begin
            if (status.finishing)
            begin
                done_next[cur_reg[cmd.worker]] = 1'b1;
                fin_next             = fin_reg + 1'b1;
                out_next.task_res    = cur_reg[cmd.worker];
                out_next.finish_tick = tick_reg;
                out_next.deadlock    = 1'b0;
                out_next.last        = (dlts_pkg::FIN_W'(fin_reg + 1'b1)
                                        == dlts_pkg::FIN_W'(TC));
                out_valid_next       = 1'b1;
            end
            if (rem_sel != '0)
                rem_next[cmd.worker] = rem_sel - 1'b1;
        end

        if (cmd.emit_deadlock)
        begin
            out_next.task_res    = '0;
            out_next.finish_tick = tick_reg;
            out_next.deadlock    = 1'b1;
            out_next.last        = 1'b1;
            out_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TC; t++)
                masks_reg[t] <= '0;
            for (int w = 0; w < WC; w++)
            begin
                rem_reg[w] <= '0;
                cur_reg[w] <= '0;
            end
            begun_reg     <= '0;
            done_reg      <= '0;
            tick_reg      <= '0;
            fin_reg       <= '0;
            base_reg      <= dlts_pkg::DURATION_BASE_RESET;
            act_reg       <= dlts_pkg::ACTIVE_WORKERS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            masks_reg     <= masks_next;
            rem_reg       <= rem_next;
            cur_reg       <= cur_next;
            begun_reg     <= begun_next;
            done_reg      <= done_next;
            tick_reg      <= tick_next;
            fin_reg       <= fin_next;
            base_reg      <= base_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_done_begun: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg & ~begun_reg) == '0)
        else $error("task done without having begun");

    a_fin_range: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg <= dlts_pkg::FIN_W'(TC))
        else $error("finished count beyond task count");

    a_retire_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.retire_w && status.finishing) |-> status.out_free)
        else $error("completion issued into a full output register");

    a_dead_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_deadlock |=> (out_valid_reg && out_reg.deadlock && out_reg.last))
        else $error("deadlock request not presented");

endmodule

`default_nettype wire

// ----- rtl/core/dependency_list_task_scheduler.sv -----
`default_nettype none

// Task scheduler over a dependency list. An edge request (kind 0) loads one
// prerequisite bit if both task indices are in range. A run request
// (kind 1) clears progress and steps through ticks; in each tick the
// controller visits the active workers one per cycle to hand out tasks,
// checks for a busy worker, then visits them again to retire them,
// waiting while a completion meets a full output register. A run ends
// after the result flagged last (a completion, or a deadlock result when
// no worker is busy while tasks remain). Configuration writes are always
// taken and must only be issued while no run is in progress.
module dependency_list_task_scheduler (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire dlts_pkg::in_t                     in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output dlts_pkg::out_t                         out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dlts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dlts_pkg::CFG_DATA_W-1:0]   cfg_data
);

    dlts_pkg::cmd_t    cmd;
    dlts_pkg::status_t status;

    assign cfg_ready = 1'b1;

    dlts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_data.kind),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dlts_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
